// ===== sv/pfa_pkg.sv =====
// Shared types and constants for the packet frame assembler.
`default_nettype none
package pfa_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned MaxPacketBytes = 2048;
  localparam int unsigned MaxLost = 5;

  localparam int unsigned SlotW = 10;
  localparam int unsigned CntW = 10;
  localparam int unsigned LenW = 12;
  localparam int unsigned PayW = 11;
  localparam int unsigned StampW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [LenW-1:0] HeaderBytes = LenW'(12);
  localparam logic [7:0] MagicFirst = 8'h52;
  localparam logic [7:0] MagicSecond = 8'h42;
  localparam logic [7:0] SofBits = 8'h01;
  localparam logic [7:0] MofBits = 8'h02;
  localparam logic [7:0] EofBits = 8'h05;
  localparam logic [7:0] MaxLostC = 8'(MaxLost);
  localparam logic [LenW:0] MaxPacketC = (LenW+1)'(MaxPacketBytes);

  localparam logic [7:0] TagReset = 8'd112;
  localparam logic [CntW-1:0] PpfReset = 10'd242;
  localparam logic [PayW-1:0] PsizeReset = 11'd1748;

  typedef enum logic [2:0] {
    ActShort    = 3'd0,
    ActMagic    = 3'd1,
    ActUnsynced = 3'd2,
    ActLost     = 3'd3,
    ActFlag     = 3'd4,
    ActOversize = 3'd5,
    ActStored   = 3'd6
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStreamTag       = 2'd0,
    CfgPacketsPerFrame = 2'd1,
    CfgPayloadSize     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]        stream_tag;
    logic [CntW-1:0]   packets_per_frame;
    logic [PayW-1:0]   payload_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        magic_first;
    logic [7:0]        magic_second;
    logic [7:0]        flag_byte;
    logic [7:0]        seq_number;
    logic [StampW-1:0] stamp;
    logic [LenW-1:0]   packet_length;
  } item_t;

  typedef struct packed {
    action_e           action;
    logic [SlotW-1:0]  slot_index;
    logic [PayW-1:0]   payload_length;
    logic              short_warning;
    logic              frame_done;
    logic [CntW-1:0]   frame_packets;
    logic [StampW-1:0] frame_stamp;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/pfa_cfg.sv =====
// Configuration registers of the packet frame assembler.
`default_nettype none
module pfa_cfg
  import pfa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgStreamTag:       cfg_d.stream_tag = cfg_wdata_i[7:0];
        CfgPacketsPerFrame: cfg_d.packets_per_frame = cfg_wdata_i[CntW-1:0];
        CfgPayloadSize:     cfg_d.payload_size = cfg_wdata_i[PayW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stream_tag <= TagReset;
      cfg_q.packets_per_frame <= PpfReset;
      cfg_q.payload_size <= PsizeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/pfa_in_stage.sv =====
// Input register holding one header item.
`default_nettype none
module pfa_in_stage
  import pfa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || adv_i;
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

// ===== sv/pfa_core.sv =====
// Header check, sync and loss tracking, slot assignment and frame close.
`default_nettype none
module pfa_core
  import pfa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  input  wire logic  adv_i,
  output result_t    res_o
);

  logic              in_sync_q, in_sync_d;
  logic [7:0]        exp_q, exp_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [CntW-1:0]   rc_q, rc_d;
  logic [StampW-1:0] prev_q, prev_d;

  logic [7:0]        sof, mof, eof;
  logic [7:0]        exp0, lost;
  logic [SlotW-1:0]  slot0, slot_g, slot_next;
  logic [CntW-1:0]   rc0, rc_g, rc_inc;
  logic [SlotW:0]    wrap_sum, wrap_sub, slot_inc, ppf_x;
  logic [LenW-1:0]   datalen;
  logic              gap, frame_gap, flag_ok, oversize, end_hit;
  action_e           act;
  result_t           res;

  always_comb begin
    sof = cfg_i.stream_tag | SofBits;
    mof = cfg_i.stream_tag | MofBits;
    eof = cfg_i.stream_tag | EofBits;
    ppf_x = {1'b0, cfg_i.packets_per_frame};

    exp0  = in_sync_q ? exp_q : item_i.seq_number;
    slot0 = in_sync_q ? slot_q : '0;
    rc0   = in_sync_q ? rc_q : '0;

    lost = item_i.seq_number - exp0;
    gap = (lost != 8'd0);
    wrap_sum = {1'b0, slot0} + {{(SlotW-7){1'b0}}, lost};
    wrap_sub = wrap_sum - ppf_x;
    frame_gap = gap && (wrap_sum >= ppf_x);
    slot_g = frame_gap ? wrap_sub[SlotW-1:0] : wrap_sum[SlotW-1:0];
    rc_g = frame_gap ? '0 : rc0;

    slot_inc = {1'b0, slot_g} + (SlotW+1)'(1);
    flag_ok = ((slot_g == '0) && (item_i.flag_byte == sof)) ||
              ((slot_inc == ppf_x) && (item_i.flag_byte == eof)) ||
              ((slot_g != '0) && (slot_inc < ppf_x) && (item_i.flag_byte == mof));

    datalen = item_i.packet_length - HeaderBytes;
    oversize = (datalen > {1'b0, cfg_i.payload_size}) ||
               ({1'b0, item_i.packet_length} > MaxPacketC);

    slot_next = slot_inc[SlotW-1:0];
    end_hit = (slot_next == cfg_i.packets_per_frame);
    rc_inc = rc_g + CntW'(1);

    if (item_i.packet_length < HeaderBytes) begin
      act = ActShort;
    end else if (item_i.magic_first != MagicFirst || item_i.magic_second != MagicSecond) begin
      act = ActMagic;
    end else if (!in_sync_q && item_i.flag_byte != sof) begin
      act = ActUnsynced;
    end else if (gap && lost > MaxLostC) begin
      act = ActLost;
    end else if (!flag_ok) begin
      act = ActFlag;
    end else if (oversize) begin
      act = ActOversize;
    end else begin
      act = ActStored;
    end

    res = '0;
    res.action = act;
    if (act == ActStored) begin
      res.slot_index = slot_g;
      res.payload_length = datalen[PayW-1:0];
      res.short_warning = (datalen != {1'b0, cfg_i.payload_size}) &&
                          (item_i.flag_byte != eof);
      res.frame_done = end_hit || frame_gap;
      if (end_hit) begin
        res.frame_packets = rc_inc;
        res.frame_stamp = item_i.stamp;
      end else if (frame_gap) begin
        res.frame_packets = rc0;
        res.frame_stamp = prev_q;
      end
    end

    in_sync_d = in_sync_q;
    exp_d = exp_q;
    slot_d = slot_q;
    rc_d = rc_q;
    prev_d = prev_q;
    case (act)
      ActLost: begin
        in_sync_d = 1'b0;
      end
      ActFlag, ActOversize: begin
        in_sync_d = (act == ActOversize);
        exp_d = item_i.seq_number;
        slot_d = slot_g;
        rc_d = rc_g;
      end
      ActStored: begin
        in_sync_d = 1'b1;
        exp_d = item_i.seq_number + 8'd1;
        slot_d = end_hit ? '0 : slot_next;
        rc_d = end_hit ? '0 : rc_inc;
        prev_d = item_i.stamp;
      end
      default: begin
        in_sync_d = in_sync_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      exp_q <= '0;
      slot_q <= '0;
      rc_q <= '0;
      prev_q <= '0;
    end else if (adv_i) begin
      in_sync_q <= in_sync_d;
      exp_q <= exp_d;
      slot_q <= slot_d;
      rc_q <= rc_d;
      prev_q <= prev_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

// ===== sv/pfa_out_stage.sv =====
// Output register holding one result item.
`default_nettype none
module pfa_out_stage
  import pfa_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== sv/packet_frame_assembler_top.sv =====
// Top level of the packet frame assembler.
// An accepted header item is held in the input register, checked by the core, and
// its result item is held in the output register until it is taken.
// Throughput: one item per cycle while the receiver takes results, set by the single
// core pass between the input register and the output register.
// Reset: asynchronous, active low; clears both stages and the sync state and
// loads the register defaults (tag 112, 242 slots, 1748 payload bytes).
`default_nettype none
module packet_frame_assembler_top
  import pfa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          magic_first_i,
  input  wire logic [7:0]          magic_second_i,
  input  wire logic [7:0]          flag_byte_i,
  input  wire logic [7:0]          seq_number_i,
  input  wire logic [StampW-1:0]   stamp_i,
  input  wire logic [LenW-1:0]     packet_length_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               action_o,
  output logic [SlotW-1:0]         slot_index_o,
  output logic [PayW-1:0]          payload_length_o,
  output logic                     short_warning_o,
  output logic                     frame_done_o,
  output logic [CntW-1:0]          frame_packets_o,
  output logic [StampW-1:0]        frame_stamp_o
);

  cfg_t    cfg;
  item_t   item_in, item_st;
  result_t res_core, res_out;
  logic    st_valid, out_room, adv;

  assign item_in.magic_first = magic_first_i;
  assign item_in.magic_second = magic_second_i;
  assign item_in.flag_byte = flag_byte_i;
  assign item_in.seq_number = seq_number_i;
  assign item_in.stamp = stamp_i;
  assign item_in.packet_length = packet_length_i;

  assign adv = st_valid && out_room;

  pfa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pfa_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .adv_i      (adv),
    .valid_o    (st_valid),
    .item_o     (item_st)
  );

  pfa_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_st),
    .adv_i  (adv),
    .res_o  (res_core)
  );

  pfa_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res_core),
    .ready_o     (out_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign action_o = res_out.action;
  assign slot_index_o = res_out.slot_index;
  assign payload_length_o = res_out.payload_length;
  assign short_warning_o = res_out.short_warning;
  assign frame_done_o = res_out.frame_done;
  assign frame_packets_o = res_out.frame_packets;
  assign frame_stamp_o = res_out.frame_stamp;

endmodule
`default_nettype wire

// ===== sv/pfa_checker.sv =====
// Port-level checks for the packet frame assembler and their binding.
`default_nettype none
module pfa_checker
  import pfa_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [2:0]          action_o,
  input wire logic [SlotW-1:0]    slot_index_o,
  input wire logic [PayW-1:0]     payload_length_o,
  input wire logic                short_warning_o,
  input wire logic                frame_done_o,
  input wire logic [CntW-1:0]     frame_packets_o,
  input wire logic [StampW-1:0]   frame_stamp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) &&
      $stable(slot_index_o) && $stable(frame_stamp_o))
    else $error("result item changed while stalled");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ActStored |->
      slot_index_o == '0 && payload_length_o == '0 && !short_warning_o && !frame_done_o)
    else $error("dropped item carries store fields");

  a_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_packets_o == '0 && frame_stamp_o == '0)
    else $error("frame fields set without a finished frame");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without an accepted item two cycles before");

endmodule

bind packet_frame_assembler_top pfa_checker u_pfa_checker (.*);
`default_nettype wire

// ===== dv/packet_frame_assembler_top_tb.sv =====
// Self-checking testbench for the packet frame assembler: directed and random header streams.
`timescale 1ns / 100ps
module packet_frame_assembler_top_tb;
  import pfa_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          magic_first_i = '0;
  logic [7:0]          magic_second_i = '0;
  logic [7:0]          flag_byte_i = '0;
  logic [7:0]          seq_number_i = '0;
  logic [StampW-1:0]   stamp_i = '0;
  logic [LenW-1:0]     packet_length_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          action_o;
  logic [SlotW-1:0]    slot_index_o;
  logic [PayW-1:0]     payload_length_o;
  logic                short_warning_o;
  logic                frame_done_o;
  logic [CntW-1:0]     frame_packets_o;
  logic [StampW-1:0]   frame_stamp_o;

  packet_frame_assembler_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .magic_first_i   (magic_first_i),
    .magic_second_i  (magic_second_i),
    .flag_byte_i     (flag_byte_i),
    .seq_number_i    (seq_number_i),
    .stamp_i         (stamp_i),
    .packet_length_i (packet_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .slot_index_o    (slot_index_o),
    .payload_length_o(payload_length_o),
    .short_warning_o (short_warning_o),
    .frame_done_o    (frame_done_o),
    .frame_packets_o (frame_packets_o),
    .frame_stamp_o   (frame_stamp_o)
  );

  always #5 clk_i = ~clk_i;

  // register mirror
  logic [7:0]      tag_cfg = TagReset;
  logic [CntW-1:0] ppf_cfg = PpfReset;
  logic [PayW-1:0] psize_cfg = PsizeReset;

  // frame reassembly state mirror
  bit                synced = 1'b0;
  logic [7:0]        next_seq = '0;
  logic [SlotW-1:0]  slot_pos = '0;
  logic [CntW-1:0]   rx_count = '0;
  logic [CntW-1:0]   frame_count = '0;
  logic [StampW-1:0] last_stamp = '0;
  logic [StampW-1:0] frame_start_stamp = '0;

  item_t   header_backlog[$];
  result_t expected_dispositions[$];
  item_t   offered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_no = 0;
  int hdrs_pushed = 0;
  int hdrs_accepted = 0;
  int results_seen = 0;
  int frames_closed = 0;
  int mismatches = 0;
  int action_hits[8];
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  int gen_slot = 0;
  logic [7:0] gen_seq = '0;

  function automatic result_t assemble_step(input item_t hdr);
    result_t res;
    logic [7:0] sof, mof, eof, lost;
    logic [LenW-1:0] datalen;
    int room, s, p;
    bit closed, fits;
    res = '0;
    closed = 1'b0;
    sof = tag_cfg | SofBits;
    mof = tag_cfg | MofBits;
    eof = tag_cfg | EofBits;
    if (hdr.packet_length < HeaderBytes) begin
      res.action = ActShort;
      return res;
    end
    if (hdr.magic_first != MagicFirst || hdr.magic_second != MagicSecond) begin
      res.action = ActMagic;
      return res;
    end
    if (!synced) begin
      if (hdr.flag_byte != sof) begin
        res.action = ActUnsynced;
        return res;
      end
      synced = 1'b1;
      next_seq = hdr.seq_number;
      slot_pos = '0;
      rx_count = '0;
      frame_count = '0;
    end
    if (next_seq != hdr.seq_number) begin
      lost = hdr.seq_number - next_seq;
      if (lost > MaxLostC) begin
        synced = 1'b0;
        res.action = ActLost;
        return res;
      end
      next_seq = hdr.seq_number;
      room = int'(ppf_cfg) - int'(slot_pos);
      if (room <= int'(lost)) begin
        slot_pos = SlotW'(int'(lost) - room);
        frame_count = rx_count;
        rx_count = '0;
        frame_start_stamp = last_stamp;
        closed = 1'b1;
      end else begin
        slot_pos = slot_pos + SlotW'(lost);
      end
    end
    s = int'(slot_pos);
    p = int'(ppf_cfg);
    fits = (s == 0 && hdr.flag_byte == sof) || (s == p - 1 && hdr.flag_byte == eof) ||
           (s > 0 && s < p - 1 && hdr.flag_byte == mof);
    if (!fits) begin
      synced = 1'b0;
      res.action = ActFlag;
      return res;
    end
    datalen = hdr.packet_length - HeaderBytes;
    if (datalen > {1'b0, psize_cfg} || hdr.packet_length > MaxPacketBytes) begin
      res.action = ActOversize;
      return res;
    end
    res.action = ActStored;
    res.slot_index = slot_pos;
    res.payload_length = datalen[PayW-1:0];
    res.short_warning = (datalen != {1'b0, psize_cfg}) && (hdr.flag_byte != eof);
    slot_pos = slot_pos + 1'b1;
    next_seq = next_seq + 1'b1;
    rx_count = rx_count + 1'b1;
    last_stamp = hdr.stamp;
    if (slot_pos == ppf_cfg) begin
      slot_pos = '0;
      frame_count = rx_count;
      rx_count = '0;
      frame_start_stamp = hdr.stamp;
      closed = 1'b1;
    end
    if (closed) begin
      res.frame_done = 1'b1;
      res.frame_packets = frame_count;
      res.frame_stamp = frame_start_stamp;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    mismatches++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got_v, want_v);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_dispositions.push_back(assemble_step(offered));
        hdrs_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (header_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = header_backlog.pop_front();
          in_valid_i <= 1'b1;
          magic_first_i <= offered.magic_first;
          magic_second_i <= offered.magic_second;
          flag_byte_i <= offered.flag_byte;
          seq_number_i <= offered.seq_number;
          stamp_i <= offered.stamp;
          packet_length_i <= offered.packet_length;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && phase_no == 5) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      action_hits[action_o]++;
      if (frame_done_o) frames_closed++;
      if (expected_dispositions.size() == 0) begin
        report_mismatch("result with no header pending, action", action_o, 0);
      end else begin
        want = expected_dispositions.pop_front();
        if (action_o !== want.action) report_mismatch("action", action_o, want.action);
        if (slot_index_o !== want.slot_index)
          report_mismatch("slot_index", slot_index_o, want.slot_index);
        if (payload_length_o !== want.payload_length)
          report_mismatch("payload_length", payload_length_o, want.payload_length);
        if (short_warning_o !== want.short_warning)
          report_mismatch("short_warning", short_warning_o, want.short_warning);
        if (frame_done_o !== want.frame_done)
          report_mismatch("frame_done", frame_done_o, want.frame_done);
        if (frame_packets_o !== want.frame_packets)
          report_mismatch("frame_packets", frame_packets_o, want.frame_packets);
        if (frame_stamp_o !== want.frame_stamp)
          report_mismatch("frame_stamp", frame_stamp_o, want.frame_stamp);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgStreamTag:       tag_cfg = 8'(val);
      CfgPacketsPerFrame: ppf_cfg = CntW'(val);
      CfgPayloadSize:     psize_cfg = PayW'(val);
      default: ;
    endcase
  endtask

  task automatic push_hdr(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] flag,
                          input logic [7:0] seq, input logic [LenW-1:0] len);
    item_t h;
    h.magic_first = m0;
    h.magic_second = m1;
    h.flag_byte = flag;
    h.seq_number = seq;
    h.stamp = $urandom;
    h.packet_length = len;
    header_backlog.push_back(h);
    hdrs_pushed++;
  endtask

  // a flag that fits no slot: drops sync if held, ignored otherwise
  task automatic push_desync();
    push_hdr(MagicFirst, MagicSecond, tag_cfg ^ 8'h08, gen_seq, LenW'(100));
    gen_slot = 0;
  endtask

  function automatic logic [7:0] slot_flag(input int slot);
    if (slot == 0) return tag_cfg | SofBits;
    if (slot == int'(ppf_cfg) - 1) return tag_cfg | EofBits;
    return tag_cfg | MofBits;
  endfunction

  function automatic logic [LenW-1:0] good_len();
    if ($urandom_range(0, 99) < 70) return LenW'(int'(psize_cfg) + 12);
    return LenW'($urandom_range(12, int'(psize_cfg) + 12));
  endfunction

  task automatic gen_stream(input int n);
    int made, roll, gap, ppf;
    logic [7:0] m0, m1;
    made = 0;
    ppf = int'(ppf_cfg);
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_hdr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 LenW'($urandom_range(0, 11)));
        made++;
      end else if (roll < 8) begin
        m0 = ($urandom_range(0, 1) == 1) ? MagicFirst : 8'($urandom);
        m1 = 8'($urandom);
        if (m0 == MagicFirst && m1 == MagicSecond) m1 = m1 ^ 8'h01;
        push_hdr(m0, m1, slot_flag(gen_slot), gen_seq, LenW'($urandom_range(12, 2048)));
        made++;
      end else if (roll < 11) begin
        push_hdr(MagicFirst, MagicSecond, 8'($urandom), 8'($urandom),
                 LenW'($urandom_range(12, 2048)));
        push_desync();
        made += 2;
      end else if (roll < 14 && psize_cfg < 11'd2036) begin
        push_hdr(MagicFirst, MagicSecond, slot_flag(gen_slot), gen_seq,
                 LenW'($urandom_range(int'(psize_cfg) + 13, 2048)));
        made++;
      end else if (roll < 17) begin
        gen_seq = gen_seq + 8'($urandom_range(6, 255));
        push_hdr(MagicFirst, MagicSecond, slot_flag(gen_slot), gen_seq, good_len());
        push_desync();
        gen_seq = 8'($urandom);
        made += 2;
      end else begin
        if (roll < 25) begin
          gap = $urandom_range(1, (ppf > 5) ? 5 : ppf - 1);
          gen_seq = gen_seq + 8'(gap);
          gen_slot = (gen_slot + gap) % ppf;
        end
        push_hdr(MagicFirst, MagicSecond, slot_flag(gen_slot), gen_seq, good_len());
        gen_slot = (gen_slot + 1) % ppf;
        gen_seq = gen_seq + 1'b1;
        made++;
      end
    end
  endtask

  task automatic drain();
    while (results_seen < hdrs_pushed) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int tag, input int ppf, input int psize,
                           input int send_pct, input int recv_pct, input int n);
    write_reg(CfgStreamTag, tag);
    write_reg(CfgPacketsPerFrame, ppf);
    write_reg(CfgPayloadSize, psize);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_no++;
    push_desync();
    gen_stream(n);
    drain();
  endtask

  initial begin
    logic [7:0] sof, mof, eof;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 83;
    write_reg(CfgStreamTag, 112);
    write_reg(CfgPacketsPerFrame, 3);
    write_reg(CfgPayloadSize, 1000);
    sof = tag_cfg | SofBits;
    mof = tag_cfg | MofBits;
    eof = tag_cfg | EofBits;
    push_hdr(MagicFirst, MagicSecond, sof, 8'd0, 12'd0);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd0, 12'd11);
    push_hdr(MagicFirst, 8'h41, sof, 8'd0, 12'd12);
    push_hdr(8'h00, MagicSecond, sof, 8'd0, 12'd12);
    push_hdr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'd2048);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd0, 12'd100);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd250, 12'd12);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd251, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, eof, 8'd252, 12'd112);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd253, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, eof, 8'd255, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd0, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd3, 12'd500);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd6, 12'd500);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd10, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd11, 12'd1013);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd11, 12'd2048);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd11, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, eof, 8'd20, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd30, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd36, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, sof, 8'd40, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, mof, 8'd41, 12'd1012);
    push_hdr(MagicFirst, MagicSecond, eof, 8'd48, 12'd1012);
    drain();

    run_phase(112, 5, 200, 22, 83, 80);
    run_phase(0, 3, 2036, 22, 83, 60);
    run_phase(255, 8, 1, 83, 22, 60);
    run_phase($urandom_range(0, 255), 1023, $urandom_range(1, 2036), 83, 22, 40);
    run_phase($urandom_range(0, 255), $urandom_range(3, 16), $urandom_range(1, 2036), 0, 0, 90);
    run_phase($urandom_range(0, 255), 4, 64, 0, 0, 90);

    $display("Ran %0d headers through %0d register settings; %0d results checked, %0d frames closed.",
             hdrs_accepted, phase_no + 1, results_seen, frames_closed);
    $display("Dispositions: short %0d, magic %0d, unsynced %0d, lost %0d, flag %0d, oversize %0d, stored %0d.",
             action_hits[ActShort], action_hits[ActMagic], action_hits[ActUnsynced],
             action_hits[ActLost], action_hits[ActFlag], action_hits[ActOversize],
             action_hits[ActStored]);
    if (mismatches == 0 && expected_dispositions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
